// ===== sv/sfbr_pkg.sv =====
// Shared types and constants for the sysex firmware block receiver.
// No dependencies; every other file refers to this package by scoped names.
package sfbr_pkg;

  localparam int PAGES_IN_BLOCK = 2;
  localparam int HEADER_BYTES   = 7;
  localparam int OFFSET_BYTES   = 4;
  localparam int REQ_INDEX      = HEADER_BYTES - 1;
  localparam int GROUP_LEN      = 8;

  localparam int BYTE7_W   = 7;
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 12;
  localparam int PAGE_W    = 11;
  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 12;
  localparam int GIDX_W    = $clog2(GROUP_LEN);
  localparam int OFF_IDX_W = $clog2(OFFSET_BYTES);
  localparam int MULT_W    = PAGE_W + $clog2(PAGES_IN_BLOCK + 1);
  localparam int CMP_W     = ((POS_W > MULT_W) ? POS_W : MULT_W) + 1;
  localparam int STAT_W    = 2;

  localparam logic [POS_W-1:0]   POS_MAX         = '1;
  localparam logic [BYTE7_W-1:0] DATA_UPLOAD_REQ = 7'h16;

  // block status codes
  localparam logic [STAT_W-1:0] BS_ACK      = 2'd0;
  localparam logic [STAT_W-1:0] BS_NAK      = 2'd1;
  localparam logic [STAT_W-1:0] BS_NOT_DATA = 2'd2;

  // configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_LEN       = 2'd0,
    CFG_APP_BASE       = 2'd1,
    CFG_FLASH_END      = 2'd2,
    CFG_ENCODED_LENGTH = 2'd3
  } cfg_reg_t;

  localparam logic [PAGE_W-1:0] PAGE_LEN_RST       = 11'd64;
  localparam logic [ADDR_W-1:0] APP_BASE_RST       = 32'd8192;
  localparam logic [ADDR_W-1:0] FLASH_END_RST      = 32'd262144;
  localparam logic [LEN_W-1:0]  ENCODED_LENGTH_RST = 12'd151;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // decode stage to address stage
  typedef struct packed {
    logic                data_vld;
    logic                stat_vld;
    logic [BYTE_W-1:0]   data;
    logic [POS_W-1:0]    idx;
    logic [ADDR_W-1:0]   base;
    logic [STAT_W-1:0]   status;
  } stage_t;

  typedef struct packed {
    logic                is_status;
    logic [BYTE_W-1:0]   out_byte;
    logic [ADDR_W-1:0]   flash_address;
    logic                page_writable;
    logic [STAT_W-1:0]   block_status;
  } res_t;

endpackage

// ===== sv/sfbr_in_if.sv =====
// Input channel: one sysex body byte per item, valid/ready handshake.
// Depends on sfbr_pkg for field widths.
interface sfbr_in_if;
  logic                         valid;
  logic                         ready;
  logic [sfbr_pkg::BYTE7_W-1:0] body_byte;
  logic                         end_of_message;

  modport source (output valid, body_byte, end_of_message, input ready);
  modport sink   (input valid, body_byte, end_of_message, output ready);
endinterface

// ===== sv/sfbr_out_if.sv =====
// Result channel: decoded data bytes and end-of-message status, valid/ready.
// Depends on sfbr_pkg for field widths.
interface sfbr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         is_status;
  logic [sfbr_pkg::BYTE_W-1:0]  out_byte;
  logic [sfbr_pkg::ADDR_W-1:0]  flash_address;
  logic                         page_writable;
  logic [sfbr_pkg::STAT_W-1:0]  block_status;

  modport source (output valid, is_status, out_byte, flash_address, page_writable,
                  block_status, input ready);
  modport sink   (input valid, is_status, out_byte, flash_address, page_writable,
                  block_status, output ready);
endinterface

// ===== sv/sfbr_unpack.sv =====
// Input register, message state and 8-to-7 unpacking; produces the stage word.
// Depends on sfbr_pkg and sfbr_in_if.
module sfbr_unpack (
  input  logic                            clk,
  input  logic                            rst_n,
  sfbr_in_if.sink                         in_ch,
  input  logic                            adv,
  input  logic [sfbr_pkg::PAGE_W-1:0]     page_len,
  input  logic [sfbr_pkg::ADDR_W-1:0]     app_base,
  input  logic [sfbr_pkg::LEN_W-1:0]      encoded_length,
  output sfbr_pkg::stage_t                stage_r
);

  logic                           in_vld_r;
  logic [sfbr_pkg::BYTE7_W-1:0]   in_byte_r;
  logic                           in_eom_r;

  logic [sfbr_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [sfbr_pkg::BYTE7_W-1:0]   held_r, held_nxt;
  logic                           held_vld_r, held_vld_nxt;
  logic [sfbr_pkg::BYTE7_W-1:0]   xor_r, xor_nxt;
  logic [sfbr_pkg::BYTE7_W-1:0]   msb_r, msb_nxt;
  logic [sfbr_pkg::GIDX_W-1:0]    gidx_r, gidx_nxt;
  logic [sfbr_pkg::POS_W-1:0]     dc_r, dc_nxt;
  logic [sfbr_pkg::ADDR_W-1:0]    off_r, off_nxt;
  logic [sfbr_pkg::BYTE7_W-1:0]   req_r, req_nxt;
  sfbr_pkg::stage_t               stage_nxt;

  logic [sfbr_pkg::BYTE_W-1:0]    dec;
  logic [sfbr_pkg::BYTE7_W-1:0]   req_c;
  logic                           ok;
  logic [sfbr_pkg::CMP_W-1:0]     dc_data;
  logic [sfbr_pkg::CMP_W-1:0]     need_data;

  assign in_ch.ready = adv;

  always_comb begin
    pos_nxt      = pos_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    xor_nxt      = xor_r;
    msb_nxt      = msb_r;
    gidx_nxt     = gidx_r;
    dc_nxt       = dc_r;
    off_nxt      = off_r;
    req_nxt      = req_r;
    stage_nxt    = '0;
    dec          = {msb_r[0], held_r};
    req_c        = '0;
    ok           = 1'b0;
    dc_data      = '0;
    need_data    = '0;

    // absorb the byte held back from the previous item
    if (in_vld_r && held_vld_r) begin
      xor_nxt = xor_r ^ held_r;
      if (pos_r != sfbr_pkg::POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r < sfbr_pkg::POS_W'(sfbr_pkg::HEADER_BYTES)) begin
          if (pos_r == sfbr_pkg::POS_W'(sfbr_pkg::REQ_INDEX)) begin
            req_nxt = held_r;
          end
        end else begin
          if (gidx_r == '0) begin
            msb_nxt = held_r;
          end else begin
            msb_nxt = msb_r >> 1;
            if (dc_r < sfbr_pkg::POS_W'(sfbr_pkg::OFFSET_BYTES)) begin
              off_nxt[sfbr_pkg::BYTE_W * int'(dc_r[sfbr_pkg::OFF_IDX_W-1:0]) +: sfbr_pkg::BYTE_W]
                = dec;
            end else begin
              stage_nxt.data_vld = 1'b1;
              stage_nxt.data     = dec;
              stage_nxt.idx      = dc_r - sfbr_pkg::POS_W'(sfbr_pkg::OFFSET_BYTES);
              stage_nxt.base     = app_base + off_r;
            end
            dc_nxt = dc_r + 1'b1;
          end
          gidx_nxt = gidx_r + 1'b1;
        end
      end
    end

    if (in_vld_r) begin
      if (!in_eom_r) begin
        held_nxt     = in_byte_r;
        held_vld_nxt = 1'b1;
      end else begin
        // checksum byte sitting at the request index doubles as the request code
        req_c = (pos_nxt == sfbr_pkg::POS_W'(sfbr_pkg::REQ_INDEX)) ? in_byte_r : req_nxt;
        dc_data   = sfbr_pkg::CMP_W'(dc_nxt) - sfbr_pkg::CMP_W'(sfbr_pkg::OFFSET_BYTES);
        need_data = sfbr_pkg::CMP_W'(sfbr_pkg::PAGES_IN_BLOCK) * sfbr_pkg::CMP_W'(page_len);
        ok = (xor_nxt == in_byte_r)
          && (pos_nxt >= sfbr_pkg::POS_W'(sfbr_pkg::HEADER_BYTES))
          && (pos_nxt != sfbr_pkg::POS_MAX)
          && ((pos_nxt - sfbr_pkg::POS_W'(sfbr_pkg::HEADER_BYTES)) == encoded_length)
          && (dc_nxt >= sfbr_pkg::POS_W'(sfbr_pkg::OFFSET_BYTES))
          && (dc_data == need_data);
        stage_nxt.stat_vld = 1'b1;
        if (pos_nxt < sfbr_pkg::POS_W'(sfbr_pkg::REQ_INDEX)
            || req_c != sfbr_pkg::DATA_UPLOAD_REQ) begin
          stage_nxt.status = sfbr_pkg::BS_NOT_DATA;
        end else begin
          stage_nxt.status = ok ? sfbr_pkg::BS_ACK : sfbr_pkg::BS_NAK;
        end
        pos_nxt      = '0;
        held_nxt     = '0;
        held_vld_nxt = 1'b0;
        xor_nxt      = '0;
        msb_nxt      = '0;
        gidx_nxt     = '0;
        dc_nxt       = '0;
        off_nxt      = '0;
        req_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      pos_r      <= '0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      xor_r      <= '0;
      msb_r      <= '0;
      gidx_r     <= '0;
      dc_r       <= '0;
      off_r      <= '0;
      req_r      <= '0;
      stage_r    <= '0;
    end else if (adv) begin
      in_vld_r   <= in_ch.valid;
      pos_r      <= pos_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      xor_r      <= xor_nxt;
      msb_r      <= msb_nxt;
      gidx_r     <= gidx_nxt;
      dc_r       <= dc_nxt;
      off_r      <= off_nxt;
      req_r      <= req_nxt;
      stage_r    <= stage_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_byte_r <= in_ch.body_byte;
      in_eom_r  <= in_ch.end_of_message;
    end
  end

endmodule

// ===== sv/sfbr_addr.sv =====
// Address stage: flash address and page range check for data bytes, status item.
// Depends on sfbr_pkg.
module sfbr_addr (
  input  sfbr_pkg::stage_t                stage,
  input  logic [sfbr_pkg::PAGE_W-1:0]     page_len,
  input  logic [sfbr_pkg::ADDR_W-1:0]     flash_end,
  output sfbr_pkg::res_t                  data_res,
  output sfbr_pkg::res_t                  stat_res
);

  logic                          wr;
  logic [sfbr_pkg::CMP_W-1:0]    lo, hi, idx_ext;
  logic [sfbr_pkg::ADDR_W:0]     pend;

  // page k holds idx in [k*len, (k+1)*len); one comparator pair per page of the block
  always_comb begin
    wr      = 1'b0;
    lo      = '0;
    hi      = '0;
    pend    = '0;
    idx_ext = sfbr_pkg::CMP_W'(stage.idx);
    for (int m = 1; m <= sfbr_pkg::PAGES_IN_BLOCK; m++) begin
      lo   = sfbr_pkg::CMP_W'(m - 1) * sfbr_pkg::CMP_W'(page_len);
      hi   = sfbr_pkg::CMP_W'(m) * sfbr_pkg::CMP_W'(page_len);
      pend = {1'b0, stage.base} + (sfbr_pkg::ADDR_W + 1)'(hi);
      if (page_len != '0 && idx_ext >= lo && idx_ext < hi
          && pend <= {1'b0, flash_end}) begin
        wr = 1'b1;
      end
    end
  end

  always_comb begin
    data_res.is_status     = 1'b0;
    data_res.out_byte      = stage.data;
    data_res.flash_address = stage.base + sfbr_pkg::ADDR_W'(stage.idx);
    data_res.page_writable = wr;
    data_res.block_status  = sfbr_pkg::BS_ACK;

    stat_res.is_status     = 1'b1;
    stat_res.out_byte      = '0;
    stat_res.flash_address = '0;
    stat_res.page_writable = 1'b0;
    stat_res.block_status  = stage.status;
  end

endmodule

// ===== sv/sfbr_out_fifo.sv =====
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on sfbr_pkg and sfbr_out_if.
module sfbr_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_a,
  input  sfbr_pkg::res_t   res_a,
  input  logic             push_b,
  input  sfbr_pkg::res_t   res_b,
  output logic             adv,
  sfbr_out_if.source       out_ch
);

  sfbr_pkg::res_t                   mem_r [sfbr_pkg::FIFO_DEPTH];
  logic [sfbr_pkg::FIFO_PTR_W-1:0]  head_r, tail_r, tail_b;
  logic [sfbr_pkg::FIFO_CNT_W-1:0]  count_r, count_nxt;
  logic                             pop;
  logic [sfbr_pkg::FIFO_CNT_W-1:0]  n_push;

  // room for an end-of-message item's two results
  assign adv    = count_r <= sfbr_pkg::FIFO_CNT_W'(sfbr_pkg::FIFO_DEPTH - 2);
  assign pop    = out_ch.valid && out_ch.ready;
  assign n_push = sfbr_pkg::FIFO_CNT_W'(push_a) + sfbr_pkg::FIFO_CNT_W'(push_b);
  assign tail_b = push_a ? tail_r + 1'b1 : tail_r;
  assign count_nxt = count_r + n_push - sfbr_pkg::FIFO_CNT_W'(pop);

  assign out_ch.valid         = count_r != '0;
  assign out_ch.is_status     = mem_r[head_r].is_status;
  assign out_ch.out_byte      = mem_r[head_r].out_byte;
  assign out_ch.flash_address = mem_r[head_r].flash_address;
  assign out_ch.page_writable = mem_r[head_r].page_writable;
  assign out_ch.block_status  = mem_r[head_r].block_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_r + sfbr_pkg::FIFO_PTR_W'(pop);
      tail_r  <= tail_r + sfbr_pkg::FIFO_PTR_W'(n_push);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[tail_r] <= res_a;
    end
    if (push_b) begin
      mem_r[tail_b] <= res_b;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sfbr_pkg::FIFO_CNT_W'(sfbr_pkg::FIFO_DEPTH))
    else $error("result queue over capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_a || push_b) |-> adv)
    else $error("push without room for two results");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == head_r + sfbr_pkg::FIFO_PTR_W'(count_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== sv/sysex_firmware_block_receiver.sv =====
// Sysex firmware block receiver: 7-bit body bytes in, unpacked flash bytes and status out.
// Usage:
//   in_ch  carries one body byte per item; end_of_message marks the checksum byte.
//   out_ch carries one result per item: a decoded data byte with its flash address
//          and page-writable flag, or (is_status=1) the block status at end of message.
//   cfg_*  writes page length, app_base, flash_end, encoded_length by index; write only
//          while no results are pending.
// One byte is always held back, so a data result appears when the following byte
// arrives; the checksum byte is never decoded and its item yields the status result.
// A result passes the input register, the decode register and the result queue
// before it is on out_ch. Throughput: one item per cycle while in_ch.ready is high.
// An end-of-message item yields up to two results, which the four-entry result queue
// absorbs; in_ch.ready drops while the queue holds more than two results, which is also
// how a stalled out_ch holds off the input.
// Reset (rst_n low at a clock edge) clears the message state and the queue and loads
// the configuration defaults: page 64, base 0x2000, end 0x40000, length 151.
// Depends on sfbr_pkg, sfbr_in_if, sfbr_out_if, sfbr_unpack, sfbr_addr, sfbr_out_fifo.
module sysex_firmware_block_receiver (
  input  logic                              clk,
  input  logic                              rst_n,
  sfbr_in_if.sink                           in_ch,
  sfbr_out_if.source                        out_ch,
  input  logic                              cfg_wr_en,
  input  logic [sfbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfbr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [sfbr_pkg::PAGE_W-1:0]  page_len_r;
  logic [sfbr_pkg::ADDR_W-1:0]  app_base_r;
  logic [sfbr_pkg::ADDR_W-1:0]  flash_end_r;
  logic [sfbr_pkg::LEN_W-1:0]   encoded_length_r;

  logic                         adv;
  sfbr_pkg::stage_t             stage_r;
  sfbr_pkg::res_t               data_res, stat_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_len_r       <= sfbr_pkg::PAGE_LEN_RST;
      app_base_r       <= sfbr_pkg::APP_BASE_RST;
      flash_end_r      <= sfbr_pkg::FLASH_END_RST;
      encoded_length_r <= sfbr_pkg::ENCODED_LENGTH_RST;
    end else if (cfg_wr_en) begin
      case (sfbr_pkg::cfg_reg_t'(cfg_index))
        sfbr_pkg::CFG_PAGE_LEN:       page_len_r       <= cfg_wdata[sfbr_pkg::PAGE_W-1:0];
        sfbr_pkg::CFG_APP_BASE:       app_base_r       <= cfg_wdata[sfbr_pkg::ADDR_W-1:0];
        sfbr_pkg::CFG_FLASH_END:      flash_end_r      <= cfg_wdata[sfbr_pkg::ADDR_W-1:0];
        sfbr_pkg::CFG_ENCODED_LENGTH: encoded_length_r <= cfg_wdata[sfbr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  sfbr_unpack u_unpack (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .adv            (adv),
    .page_len       (page_len_r),
    .app_base       (app_base_r),
    .encoded_length (encoded_length_r),
    .stage_r        (stage_r)
  );

  sfbr_addr u_addr (
    .stage     (stage_r),
    .page_len  (page_len_r),
    .flash_end (flash_end_r),
    .data_res  (data_res),
    .stat_res  (stat_res)
  );

  sfbr_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_a (adv && stage_r.data_vld),
    .res_a  (data_res),
    .push_b (adv && stage_r.stat_vld),
    .res_b  (stat_res),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/sysex_firmware_block_receiver_test.sv =====
// Self-checking testbench for sysex_firmware_block_receiver: directed table, then random
// sysex bodies per config phase, checked against an in-bench unpack/address predictor.
// Depends on sfbr_pkg, sfbr_in_if, sfbr_out_if and the RTL of the block.
`timescale 1ns / 1ps

module sysex_firmware_block_receiver_test;

  localparam int GAP_MAX       = 18;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int REPORT_LINES  = 40;

  localparam logic LAST      = 1'b1;
  localparam logic MORE      = 1'b0;
  localparam logic CHECKED   = 1'b1;
  localparam logic PREDICTED = 1'b0;

  // one row of the directed table; status is only used on checked rows
  typedef struct packed {
    logic                         checked;
    logic [sfbr_pkg::STAT_W-1:0]  status;
    logic                         last;
    logic [sfbr_pkg::BYTE7_W-1:0] body;
  } dir_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [sfbr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sfbr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sfbr_in_if  in_ch ();
  sfbr_out_if out_ch ();

  sysex_firmware_block_receiver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the registers
  logic [sfbr_pkg::PAGE_W-1:0]  page_bytes;
  logic [sfbr_pkg::ADDR_W-1:0]  app_start;
  logic [sfbr_pkg::ADDR_W-1:0]  flash_limit;
  logic [sfbr_pkg::LEN_W-1:0]   payload_len;

  // predictor copy of the message state
  int unsigned                  body_pos;
  int unsigned                  unpacked_cnt;
  int unsigned                  group_pos;
  logic [sfbr_pkg::BYTE7_W-1:0] held_body;
  bit                           held_ok;
  logic [sfbr_pkg::BYTE7_W-1:0] sum7;
  logic [sfbr_pkg::BYTE7_W-1:0] top_bits;
  logic [sfbr_pkg::BYTE7_W-1:0] request;
  logic [sfbr_pkg::ADDR_W-1:0]  flash_offset;

  sfbr_pkg::res_t flash_results_due[$];
  int   err_count    = 0;
  int   result_no    = 0;
  int   stall_cycles = 0;
  bit   idling       = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    err_count++;
    if (err_count <= REPORT_LINES) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", result_no, field, got, want));
  endtask

  function automatic logic [sfbr_pkg::BYTE7_W-1:0] rand7();
    return sfbr_pkg::BYTE7_W'($urandom_range(0, 127));
  endfunction

  function automatic sfbr_pkg::res_t block_status_item(input logic [sfbr_pkg::STAT_W-1:0] st);
    sfbr_pkg::res_t r;
    r = '0;
    r.is_status = 1'b1;
    r.block_status = st;
    return r;
  endfunction

  function automatic void clear_message();
    body_pos = 0;
    unpacked_cnt = 0;
    group_pos = 0;
    held_body = '0;
    held_ok = 1'b0;
    sum7 = '0;
    top_bits = '0;
    request = '0;
    flash_offset = '0;
  endfunction

  // takes one held-back body byte into the header, offset or data stream
  function automatic void unpack_stored_byte(input logic [sfbr_pkg::BYTE7_W-1:0] b);
    logic [sfbr_pkg::BYTE_W-1:0] v;
    int unsigned                 pos;
    int unsigned                 idx;
    int unsigned                 page;
    logic [sfbr_pkg::ADDR_W-1:0] base;
    logic [63:0]                 page_end;
    sfbr_pkg::res_t              r;
    sum7 ^= b;
    if (body_pos >= sfbr_pkg::POS_MAX) return;  // saturated: only the checksum sees it
    pos = body_pos;
    body_pos++;
    if (pos < sfbr_pkg::HEADER_BYTES) begin
      if (pos == sfbr_pkg::REQ_INDEX) request = b;
      return;
    end
    if (group_pos == 0) begin
      top_bits = b;
    end else begin
      v = {top_bits[0], b};
      top_bits = top_bits >> 1;
      if (unpacked_cnt < sfbr_pkg::OFFSET_BYTES) begin
        flash_offset = flash_offset | (32'(v) << (8 * unpacked_cnt));
      end else begin
        idx = unpacked_cnt - sfbr_pkg::OFFSET_BYTES;
        base = app_start + flash_offset;
        r = '0;
        r.out_byte = v;
        r.flash_address = base + idx;
        if (page_bytes != 0) begin
          page = idx / page_bytes;
          if (page < sfbr_pkg::PAGES_IN_BLOCK) begin
            // page end is taken without wrap
            page_end = 64'(base) + 64'(page + 1) * 64'(page_bytes);
            r.page_writable = (page_end <= 64'(flash_limit));
          end
        end
        flash_results_due.push_back(r);
      end
      unpacked_cnt++;
    end
    group_pos = (group_pos + 1) % sfbr_pkg::GROUP_LEN;
  endfunction

  function automatic void receive_body_byte(input logic [sfbr_pkg::BYTE7_W-1:0] b,
                                            input logic last);
    logic [sfbr_pkg::BYTE7_W-1:0] req;
    logic [sfbr_pkg::STAT_W-1:0]  st;
    bit                           ok;
    if (held_ok) unpack_stored_byte(held_body);
    if (!last) begin
      held_body = b;
      held_ok = 1'b1;
      return;
    end
    // a checksum at the request index stands in for the request code
    req = (body_pos == sfbr_pkg::REQ_INDEX) ? b : request;
    if (body_pos < sfbr_pkg::REQ_INDEX || req != sfbr_pkg::DATA_UPLOAD_REQ) begin
      st = sfbr_pkg::BS_NOT_DATA;
    end else begin
      ok = sum7 == b && body_pos >= sfbr_pkg::HEADER_BYTES && body_pos < sfbr_pkg::POS_MAX
           && (body_pos - sfbr_pkg::HEADER_BYTES) == payload_len
           && unpacked_cnt >= sfbr_pkg::OFFSET_BYTES
           && (unpacked_cnt - sfbr_pkg::OFFSET_BYTES)
              == sfbr_pkg::PAGES_IN_BLOCK * page_bytes;
      st = ok ? sfbr_pkg::BS_ACK : sfbr_pkg::BS_NAK;
    end
    flash_results_due.push_back(block_status_item(st));
    clear_message();
  endfunction

  task automatic push_item(input logic [sfbr_pkg::BYTE7_W-1:0] b, input logic last,
                           input bit drain);
    int gap;
    gap = idling ? $urandom_range(0, GAP_MAX) : 0;
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      while (drain && flash_results_due.size() != 0) @(posedge clk);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.body_byte      <= b;
    in_ch.end_of_message <= last;
    do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    receive_body_byte(b, last);
  endtask

  task automatic write_reg(input sfbr_pkg::cfg_reg_t id,
                           input logic [sfbr_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= id;
    cfg_wdata <= val;
    @(posedge clk);
    case (id)
      sfbr_pkg::CFG_PAGE_LEN:       page_bytes = val[sfbr_pkg::PAGE_W-1:0];
      sfbr_pkg::CFG_APP_BASE:       app_start = val;
      sfbr_pkg::CFG_FLASH_END:      flash_limit = val;
      sfbr_pkg::CFG_ENCODED_LENGTH: payload_len = val[sfbr_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  // only between messages, once the block has drained
  task automatic load_config(input int unsigned ps, input logic [sfbr_pkg::ADDR_W-1:0] base,
                             input logic [sfbr_pkg::ADDR_W-1:0] fend,
                             input int unsigned len);
    in_ch.valid <= 1'b0;
    while (flash_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    // junk above the register width must be dropped
    write_reg(sfbr_pkg::CFG_PAGE_LEN, ($urandom << sfbr_pkg::PAGE_W) | ps);
    write_reg(sfbr_pkg::CFG_APP_BASE, base);
    write_reg(sfbr_pkg::CFG_FLASH_END, fend);
    write_reg(sfbr_pkg::CFG_ENCODED_LENGTH, ($urandom << sfbr_pkg::LEN_W) | len);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_message();
    logic [sfbr_pkg::BYTE7_W-1:0] body[$];
    logic [sfbr_pkg::BYTE_W-1:0]  data[$];
    logic [sfbr_pkg::BYTE7_W-1:0] sum;
    logic [sfbr_pkg::BYTE7_W-1:0] msb;
    logic [sfbr_pkg::BYTE7_W-1:0] code;
    logic [sfbr_pkg::BYTE7_W-1:0] check;
    logic [sfbr_pkg::ADDR_W-1:0]  off;
    int                           kind;
    int                           n;
    int                           cnt;
    bit                           drain;
    kind = int'($urandom_range(0, 99));
    if (kind < 70) begin
      // data upload block, mostly with a good request code
      repeat (sfbr_pkg::REQ_INDEX) body.push_back(rand7());
      if (kind < 60) begin
        body.push_back(sfbr_pkg::DATA_UPLOAD_REQ);
      end else begin
        code = sfbr_pkg::BYTE7_W'($urandom_range(0, 126));
        if (code >= sfbr_pkg::DATA_UPLOAD_REQ) code++;
        body.push_back(code);
      end
      if (page_bytes <= 16)
        n = sfbr_pkg::OFFSET_BYTES + sfbr_pkg::PAGES_IN_BLOCK * int'(page_bytes);
      else n = int'($urandom_range(0, 40));
      if ($urandom_range(0, 4) == 0) begin
        n = n + int'($urandom_range(0, 6)) - 3;
        if (n < 0) n = 0;
      end
      off = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom;
      for (int i = 0; i < n; i++) begin
        if (i < sfbr_pkg::OFFSET_BYTES) data.push_back(off[8*i +: 8]);
        else data.push_back(sfbr_pkg::BYTE_W'($urandom_range(0, 255)));
      end
      // 8-to-7 packing; unused top bits of a short group stay random
      for (int g = 0; g < n; g += sfbr_pkg::GROUP_LEN - 1) begin
        cnt = (n - g < sfbr_pkg::GROUP_LEN - 1) ? n - g : sfbr_pkg::GROUP_LEN - 1;
        msb = rand7();
        for (int j = 0; j < cnt; j++) msb[j] = data[g+j][sfbr_pkg::BYTE_W-1];
        body.push_back(msb);
        for (int j = 0; j < cnt; j++) body.push_back(data[g+j][sfbr_pkg::BYTE7_W-1:0]);
      end
    end else if (kind < 80) begin
      repeat (sfbr_pkg::REQ_INDEX) body.push_back(rand7());
    end else if (kind < 90) begin
      repeat ($urandom_range(0, 5)) body.push_back(rand7());
    end else begin
      repeat ($urandom_range(sfbr_pkg::HEADER_BYTES, 30)) body.push_back(rand7());
      if ($urandom_range(0, 1)) body[sfbr_pkg::REQ_INDEX] = sfbr_pkg::DATA_UPLOAD_REQ;
    end
    sum = '0;
    foreach (body[i]) sum ^= body[i];
    if (kind >= 70 && kind < 80)
      check = $urandom_range(0, 1) ? sfbr_pkg::DATA_UPLOAD_REQ : rand7();
    else if (kind >= 90 || $urandom_range(0, 9) == 0)
      check = rand7();
    else
      check = sum;
    drain = ($urandom_range(0, 14) == 0);
    for (int i = 0; i <= body.size(); i++)
      push_item(i < body.size() ? body[i] : check, i == body.size(), drain && i == 0);
  endtask

  task automatic run_phase(input int unsigned ps, input logic [sfbr_pkg::ADDR_W-1:0] base,
                           input logic [sfbr_pkg::ADDR_W-1:0] fend, input int unsigned len,
                           input int msgs, input bit idle);
    load_config(ps, base, fend, len);
    idling = idle;
    repeat (msgs) send_message();
  endtask

  // result side: random ready, check each result against the oldest expectation
  initial begin : result_side
    sfbr_pkg::res_t want;
    int             gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = idling ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      result_no++;
      if (flash_results_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", result_no));
      end else begin
        want = flash_results_due.pop_front();
        check_field("is_status", 32'(out_ch.is_status), 32'(want.is_status));
        check_field("out_byte", 32'(out_ch.out_byte), 32'(want.out_byte));
        check_field("flash_address", out_ch.flash_address, want.flash_address);
        check_field("page_writable", 32'(out_ch.page_writable), 32'(want.page_writable));
        check_field("block_status", 32'(out_ch.block_status), 32'(want.block_status));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("sysex_firmware_block_receiver_test: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t                    directed_rows [24];
    logic [sfbr_pkg::ADDR_W-1:0] base_pick;
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_index            = sfbr_pkg::CFG_PAGE_LEN;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.body_byte      = '0;
    in_ch.end_of_message = 1'b0;
    page_bytes           = sfbr_pkg::PAGE_LEN_RST;
    app_start            = sfbr_pkg::APP_BASE_RST;
    flash_limit          = sfbr_pkg::FLASH_END_RST;
    payload_len          = sfbr_pkg::ENCODED_LENGTH_RST;
    clear_message();

    directed_rows = '{
      // body is nothing but a checksum
      {CHECKED, sfbr_pkg::BS_NOT_DATA, LAST, 7'h7f},
      // header-only body: the checksum sits on the request index
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h00}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h7f},
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h00}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h7f},
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h00}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h7f},
      {CHECKED, sfbr_pkg::BS_NAK, LAST, 7'h16},
      // short upload: offset 0x1000, then bytes 0xff, 0x00, 0x80
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h01}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h02},
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h04}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h08},
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h40}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h7f},
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h16},
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h50}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h00},
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h10}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h00},
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h00}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h7f},
      {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h00}, {PREDICTED, sfbr_pkg::BS_ACK, MORE, 7'h00},
      {CHECKED, sfbr_pkg::BS_NAK, LAST, 7'h2a}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].body, directed_rows[i].last, 1'b0);
      if (directed_rows[i].checked)
        flash_results_due[flash_results_due.size()-1] =
          block_status_item(directed_rows[i].status);
    end

    run_phase(8, 32'h0000_0000, 32'hffff_ffff, 23, 6, 1'b1);
    run_phase(0, 32'hffff_ffff, 32'h0000_0000, 5, 6, 1'b1);
    base_pick = $urandom;
    run_phase(12, base_pick, base_pick + $urandom_range(0, 340), 32, 3, 1'b1);
    run_phase(1024, 32'h0003_ff00, 32'h0004_0000, 0, 3, 1'b1);
    run_phase(2047, $urandom, $urandom, 4095, 2, 1'b1);
    // no idling on either side
    run_phase(8, $urandom, $urandom, 23, 2, 1'b0);
    base_pick = $urandom;
    run_phase(16, base_pick, base_pick + $urandom_range(0, 400), 42, 3, 1'b1);
    run_phase(8, 32'h0000_2000, 32'h0000_2090, 23, 4, 1'b0);

    in_ch.valid <= 1'b0;
    while (flash_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("sysex_firmware_block_receiver_test: PASS");
    else
      $display("sysex_firmware_block_receiver_test: FAIL");
    $finish;
  end

endmodule
